FILE: src/internal_to_cartesian_point_macros.svh
// ----------------------------------------------------------------------------
// internal_to_cartesian_point assertion macros
// Clocked, reset-qualified assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef INTERNAL_TO_CARTESIAN_POINT_MACROS_SVH
`define INTERNAL_TO_CARTESIAN_POINT_MACROS_SVH

// Property sampled on clk, switched off while rst_n is low
`define ITC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in this cycle, consequent in the next
`define ITC_ASSERT_NEXT(label, ante, cons, msg) \
    `ITC_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: src/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// Shared formats, constants and cell types for the point placement pipeline.
// ----------------------------------------------------------------------------
package itc_pkg;

    // Field formats
    localparam int FRAC_BITS  = 16;   // fraction bits of coordinates, distance, angles
    localparam int DIS_W      = 24;   // unsigned Q8.16 distance
    localparam int ANGLE_W    = 26;   // signed degrees * 2^16
    localparam int COORD_W    = 32;   // signed Q16.16 coordinate

    // Rotator formats
    localparam int ANG_FRAC   = 24;   // residual angle fraction bits
    localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
    localparam int TRIG_FRAC  = 30;   // sine and cosine in Q30
    localparam int XY_W       = 32;
    localparam int Z_W        = 32;
    localparam int RED_W      = ANGLE_W + 2;

    localparam int MAX_STAGES      = 24;
    localparam int TRIG_STAGES_DEF = 16;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // atan(2^-i) in degrees * 2^24, rounded
    localparam logic signed [Z_W-1:0] ATAN_DEG [MAX_STAGES] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = COORD_W;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

    // One rotator lane: vector and residual angle
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } itc_lane_t;

    // Contents of one cell of the chain
    typedef struct packed {
        logic [DIS_W-1:0] dis;
        logic             neg_a;
        logic             neg_d;
        itc_lane_t        ang;
        itc_lane_t        dih;
    } itc_cell_t;

endpackage

FILE: src/internal_to_cartesian_point.sv
// ----------------------------------------------------------------------------
// internal_to_cartesian_point
// Places one point from bond length, bond angle and torsion angle against
// a fixed reference frame around a configurable origin.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries bond_length (Q8.16) and the
//   bond and torsion angles (degrees * 2^16). Output channel (out_valid /
//   out_stall) carries point_x/y/z in Q16.16, saturated. The user must
//   write origin_x/y/z through cfg_write / cfg_index / cfg_data only while
//   the block is idle, not enforced by it; unused-index writes are dropped.
// Timing
//   One transfer per cycle while the skid register is empty. From input
//   transfer to out_valid the path holds one entry stage, one cell per
//   rotation step (clamped at 24 rotator cells), six back-end stages and
//   the output register.
//   When out_stall holds the output, one further result parks in a skid
//   register; in_stall then rises and the whole pipeline holds until the
//   output moves. in_stall is a register output.
// Reset
//   rst_n clears the origin registers and all valid bits; nothing is in
//   flight afterwards and no clearing pass is needed.
// ----------------------------------------------------------------------------
module internal_to_cartesian_point #(
    parameter int TRIG_STAGES = itc_pkg::TRIG_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_write,
    input  logic        [itc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [itc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [itc_pkg::DIS_W-1:0]      bond_length,
    input  logic signed [itc_pkg::ANGLE_W-1:0]    bond_angle,
    input  logic signed [itc_pkg::ANGLE_W-1:0]    torsion_angle,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [itc_pkg::COORD_W-1:0]    point_x,
    output logic signed [itc_pkg::COORD_W-1:0]    point_y,
    output logic signed [itc_pkg::COORD_W-1:0]    point_z
);

    localparam int NUM_CELLS = (TRIG_STAGES < itc_pkg::MAX_STAGES) ?
                               TRIG_STAGES : itc_pkg::MAX_STAGES;
    localparam int CW = itc_pkg::COORD_W;

    logic signed [CW-1:0] origin_x_reg, origin_y_reg, origin_z_reg;

    logic               pipe_en;
    logic               chain_valid [NUM_CELLS+1];
    itc_pkg::itc_cell_t chain_data  [NUM_CELLS+1];

    logic                 res_valid;
    logic signed [CW-1:0] res_x, res_y, res_z;

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic signed [CW-1:0] point_x_reg, point_y_reg, point_z_reg;
    logic signed [CW-1:0] point_x_next, point_y_next, point_z_next;
    logic signed [CW-1:0] skid_x_reg, skid_y_reg, skid_z_reg;
    logic signed [CW-1:0] skid_x_next, skid_y_next, skid_z_next;
    logic                 out_take;
    logic                 res_arrive;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                itc_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                itc_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                itc_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless a result is parked in the skid register
    assign pipe_en  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    itc_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_valid      (in_valid),
        .bond_length   (bond_length),
        .bond_angle    (bond_angle),
        .torsion_angle (torsion_angle),
        .dn_valid      (chain_valid[0]),
        .dn_data       (chain_data[0])
    );

    // Rotator chain, one cell per step
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        itc_cordic_cell #(
            .STAGE_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (pipe_en),
            .up_valid (chain_valid[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    itc_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .up_valid  (chain_valid[NUM_CELLS]),
        .up_data   (chain_data[NUM_CELLS]),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .res_valid (res_valid),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z)
    );

    // Output register with one skid entry behind it
    assign out_take   = out_valid_reg && !out_stall;
    assign res_arrive = pipe_en && res_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        point_x_next    = point_x_reg;
        point_y_next    = point_y_reg;
        point_z_next    = point_z_reg;
        skid_x_next     = skid_x_reg;
        skid_y_next     = skid_y_reg;
        skid_z_next     = skid_z_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                point_x_next    = skid_x_reg;
                point_y_next    = skid_y_reg;
                point_z_next    = skid_z_reg;
            end
            else if (res_arrive)
            begin
                out_valid_next = 1'b1;
                point_x_next   = res_x;
                point_y_next   = res_y;
                point_z_next   = res_z;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (res_arrive)
        begin
            skid_valid_next = 1'b1;
            skid_x_next     = res_x;
            skid_y_next     = res_y;
            skid_z_next     = res_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_x_reg <= point_x_next;
        point_y_reg <= point_y_next;
        point_z_reg <= point_z_next;
        skid_x_reg  <= skid_x_next;
        skid_y_reg  <= skid_y_next;
        skid_z_reg  <= skid_z_next;
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign point_z   = point_z_reg;

endmodule

FILE: src/itc_prep.sv
// ----------------------------------------------------------------------------
// itc_prep
// Entry stage: wraps both angles into one turn, folds them into +-90 degrees
// and loads the first cell of the rotator chain.
// ----------------------------------------------------------------------------
module itc_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic        [itc_pkg::DIS_W-1:0]      bond_length,
    input  logic signed [itc_pkg::ANGLE_W-1:0]    bond_angle,
    input  logic signed [itc_pkg::ANGLE_W-1:0]    torsion_angle,
    output logic                                  dn_valid,
    output itc_pkg::itc_cell_t                    dn_data
);

    localparam int RW = itc_pkg::RED_W;
    localparam logic signed [RW-1:0] FULL_TURN    = RW'(360 << itc_pkg::FRAC_BITS);
    localparam logic signed [RW-1:0] HALF_TURN    = RW'(180 << itc_pkg::FRAC_BITS);
    localparam logic signed [RW-1:0] QUARTER_TURN = RW'(90 << itc_pkg::FRAC_BITS);

    typedef struct packed {
        logic                           neg;
        logic signed [itc_pkg::Z_W-1:0] z;
    } red_t;

    logic               dn_valid_reg;
    itc_pkg::itc_cell_t dn_data_reg;
    itc_pkg::itc_cell_t dn_data_next;
    red_t               red_a;
    red_t               red_d;

    // Wrap into [-180,180), fold into [-90,90] and rescale to 24 fraction bits
    function automatic red_t reduce(input logic signed [itc_pkg::ANGLE_W-1:0] a);
        logic signed [RW-1:0] w;
        logic signed [RW-1:0] r;
        red_t                 res;
        w = RW'(a);
        if (w >= HALF_TURN)
        begin
            r = w - FULL_TURN;
        end
        else if (w < -HALF_TURN)
        begin
            r = w + FULL_TURN;
        end
        else
        begin
            r = w;
        end
        res.neg = 1'b0;
        if (r > QUARTER_TURN)
        begin
            r       = r - HALF_TURN;
            res.neg = 1'b1;
        end
        else if (r < -QUARTER_TURN)
        begin
            r       = r + HALF_TURN;
            res.neg = 1'b1;
        end
        res.z = itc_pkg::Z_W'(r) <<< itc_pkg::ANG_SHIFT;
        return res;
    endfunction

    assign red_a = reduce(bond_angle);
    assign red_d = reduce(torsion_angle);

    // First cell contents: unit vector scaled by the gain, angle residual
    always_comb
    begin
        dn_data_next.dis   = bond_length;
        dn_data_next.neg_a = red_a.neg;
        dn_data_next.neg_d = red_d.neg;
        dn_data_next.ang.x = itc_pkg::CORDIC_GAIN;
        dn_data_next.ang.y = '0;
        dn_data_next.ang.z = red_a.z;
        dn_data_next.dih.x = itc_pkg::CORDIC_GAIN;
        dn_data_next.dih.y = '0;
        dn_data_next.dih.z = red_d.z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dn_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_data_reg <= dn_data_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

endmodule

FILE: src/itc_cordic_cell.sv
// ----------------------------------------------------------------------------
// itc_cordic_cell
// One micro-rotation of the sine/cosine chain, applied to both angle lanes,
// with the distance and sign flags carried alongside.
// ----------------------------------------------------------------------------
module itc_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               up_valid,
    input  itc_pkg::itc_cell_t up_data,
    output logic               dn_valid,
    output itc_pkg::itc_cell_t dn_data
);

    localparam logic signed [itc_pkg::Z_W-1:0] ATAN_STEP = itc_pkg::ATAN_DEG[STAGE_IDX];

    logic               dn_valid_reg;
    itc_pkg::itc_cell_t dn_data_reg;
    itc_pkg::itc_cell_t dn_data_next;

    // Rotate towards zero residual; shifts are arithmetic (floor)
    function automatic itc_pkg::itc_lane_t rotate(input itc_pkg::itc_lane_t l);
        logic signed [itc_pkg::XY_W-1:0] dx;
        logic signed [itc_pkg::XY_W-1:0] dy;
        itc_pkg::itc_lane_t              r;
        dx = l.x >>> STAGE_IDX;
        dy = l.y >>> STAGE_IDX;
        if (!l.z[itc_pkg::Z_W-1])
        begin
            r.x = l.x - dy;
            r.y = l.y + dx;
            r.z = l.z - ATAN_STEP;
        end
        else
        begin
            r.x = l.x + dy;
            r.y = l.y - dx;
            r.z = l.z + ATAN_STEP;
        end
        return r;
    endfunction

    always_comb
    begin
        dn_data_next     = up_data;
        dn_data_next.ang = rotate(up_data.ang);
        dn_data_next.dih = rotate(up_data.dih);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dn_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_data_reg <= dn_data_next;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

endmodule

FILE: src/itc_tail.sv
// ----------------------------------------------------------------------------
// itc_tail
// Back end: applies the fold signs, scales sine and cosine by the distance,
// rounds, adds the origin and saturates to Q16.16. Six register stages.
// ----------------------------------------------------------------------------
module itc_tail (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 up_valid,
    input  itc_pkg::itc_cell_t                   up_data,
    input  logic signed [itc_pkg::COORD_W-1:0]   origin_x,
    input  logic signed [itc_pkg::COORD_W-1:0]   origin_y,
    input  logic signed [itc_pkg::COORD_W-1:0]   origin_z,
    output logic                                 res_valid,
    output logic signed [itc_pkg::COORD_W-1:0]   res_x,
    output logic signed [itc_pkg::COORD_W-1:0]   res_y,
    output logic signed [itc_pkg::COORD_W-1:0]   res_z
);

    localparam int XY_W    = itc_pkg::XY_W;
    localparam int CW      = itc_pkg::COORD_W;
    localparam int TF      = itc_pkg::TRIG_FRAC;
    localparam int PROD_W  = itc_pkg::DIS_W + 1 + XY_W;
    localparam int XT_W    = PROD_W - TF;
    localparam int Q_W     = PROD_W - (TF - 2);
    localparam int YP_W    = Q_W + XY_W;
    localparam int YT_W    = YP_W - (TF + 2);
    localparam int SUM_W   = CW + 2;
    localparam int N_STAGE = 6;

    localparam logic signed [PROD_W-1:0] RND_X  = PROD_W'(64'sd1 <<< (TF - 1));
    localparam logic signed [PROD_W-1:0] RND_Q  = PROD_W'(64'sd1 <<< (TF - 3));
    localparam logic signed [YP_W-1:0]   RND_YZ = YP_W'(64'sd1 <<< (TF + 1));
    localparam logic signed [SUM_W-1:0]  ONE    = SUM_W'(64'sd1 <<< itc_pkg::FRAC_BITS);
    localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0]  SAT_LO = SUM_W'(-(64'sd1 <<< (CW - 1)));

    logic [N_STAGE-1:0] vld_reg;

    // stage 0: signed trig values
    logic        [itc_pkg::DIS_W-1:0] s0_dis_reg;
    logic signed [XY_W-1:0]           s0_ca_reg, s0_sa_reg, s0_cd_reg, s0_sd_reg;
    // stage 1: distance products
    logic signed [PROD_W-1:0]         s1_pa_reg, s1_ps_reg;
    logic signed [PROD_W-1:0]         s1_pa_next, s1_ps_next;
    logic signed [XY_W-1:0]           s1_cd_reg, s1_sd_reg;
    // stage 2: rounded x term and projected length
    logic signed [PROD_W-1:0]         pa_rnd, ps_rnd;
    logic signed [XT_W-1:0]           s2_xt_reg, s2_xt_next;
    logic signed [Q_W-1:0]            s2_q_reg, s2_q_next;
    logic signed [XY_W-1:0]           s2_cd_reg, s2_sd_reg;
    // stage 3: y/z products, x coordinate
    logic signed [YP_W-1:0]           s3_py_reg, s3_pz_reg, s3_py_next, s3_pz_next;
    logic signed [SUM_W-1:0]          px_sum;
    logic signed [CW-1:0]             s3_px_reg, s3_px_next;
    // stage 4: rounded y/z terms
    logic signed [YP_W-1:0]           py_rnd, pz_rnd;
    logic signed [YT_W-1:0]           s4_yt_reg, s4_zt_reg, s4_yt_next, s4_zt_next;
    logic signed [CW-1:0]             s4_px_reg;
    // stage 5: y/z coordinates
    logic signed [SUM_W-1:0]          py_sum, pz_sum;
    logic signed [CW-1:0]             s5_px_reg, s5_py_reg, s5_pz_reg, s5_py_next, s5_pz_next;

    function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[CW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // distance times cosine and sine of the bond angle
    assign s1_pa_next = $signed({1'b0, s0_dis_reg}) * s0_ca_reg;
    assign s1_ps_next = $signed({1'b0, s0_dis_reg}) * s0_sa_reg;

    // round to nearest, ties upwards
    assign pa_rnd     = s1_pa_reg + RND_X;
    assign ps_rnd     = s1_ps_reg + RND_Q;
    assign s2_xt_next = pa_rnd[PROD_W-1:TF];
    assign s2_q_next  = ps_rnd[PROD_W-1:TF-2];

    // projected length times torsion cosine and sine; x lands here
    assign s3_py_next = s2_q_reg * s2_cd_reg;
    assign s3_pz_next = s2_q_reg * s2_sd_reg;
    assign px_sum     = SUM_W'(origin_x) + ONE - SUM_W'(s2_xt_reg);
    assign s3_px_next = sat(px_sum);

    assign py_rnd     = s3_py_reg + RND_YZ;
    assign pz_rnd     = s3_pz_reg + RND_YZ;
    assign s4_yt_next = py_rnd[YP_W-1:TF+2];
    assign s4_zt_next = pz_rnd[YP_W-1:TF+2];

    assign py_sum     = SUM_W'(origin_y) + SUM_W'(s4_yt_reg);
    assign pz_sum     = SUM_W'(origin_z) + SUM_W'(s4_zt_reg);
    assign s5_py_next = sat(py_sum);
    assign s5_pz_next = sat(pz_sum);

    // valid bits follow the data through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N_STAGE-2:0], up_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dis_reg <= up_data.dis;
            s0_ca_reg  <= up_data.neg_a ? -up_data.ang.x : up_data.ang.x;
            s0_sa_reg  <= up_data.neg_a ? -up_data.ang.y : up_data.ang.y;
            s0_cd_reg  <= up_data.neg_d ? -up_data.dih.x : up_data.dih.x;
            s0_sd_reg  <= up_data.neg_d ? -up_data.dih.y : up_data.dih.y;

            s1_pa_reg  <= s1_pa_next;
            s1_ps_reg  <= s1_ps_next;
            s1_cd_reg  <= s0_cd_reg;
            s1_sd_reg  <= s0_sd_reg;

            s2_xt_reg  <= s2_xt_next;
            s2_q_reg   <= s2_q_next;
            s2_cd_reg  <= s1_cd_reg;
            s2_sd_reg  <= s1_sd_reg;

            s3_py_reg  <= s3_py_next;
            s3_pz_reg  <= s3_pz_next;
            s3_px_reg  <= s3_px_next;

            s4_yt_reg  <= s4_yt_next;
            s4_zt_reg  <= s4_zt_next;
            s4_px_reg  <= s3_px_reg;

            s5_px_reg  <= s4_px_reg;
            s5_py_reg  <= s5_py_next;
            s5_pz_reg  <= s5_pz_next;
        end
    end

    assign res_valid = vld_reg[N_STAGE-1];
    assign res_x     = s5_px_reg;
    assign res_y     = s5_py_reg;
    assign res_z     = s5_pz_reg;

endmodule

FILE: src/itc_checker.sv
// ----------------------------------------------------------------------------
// itc_checker
// Port-level checks of the output handshake and the skid register behaviour.
// ----------------------------------------------------------------------------
`include "internal_to_cartesian_point_macros.svh"

module itc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [itc_pkg::COORD_W-1:0] point_x,
    input logic signed [itc_pkg::COORD_W-1:0] point_y,
    input logic signed [itc_pkg::COORD_W-1:0] point_z
);

    logic [3*itc_pkg::COORD_W-1:0] point_all;

    // all three coordinates as one word
    assign point_all = {point_x, point_y, point_z};

    // a held result stays offered and unchanged
    `ITC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "held result withdrawn")
    `ITC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(point_all), "held result changed")

    // input back-pressure only while a result sits at the output
    `ITC_ASSERT(a_stall_needs_out, in_stall |-> out_valid, "in_stall without a pending result")

    // skid fills only from a stalled output transfer
    `ITC_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "stray skid fill")

    // skid drains as soon as the output moves
    `ITC_ASSERT_NEXT(a_stall_release, in_stall && !out_stall, !in_stall, "skid not drained")

endmodule

bind internal_to_cartesian_point itc_checker u_itc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
);

FILE: dv/internal_to_cartesian_point_tb.sv
// ----------------------------------------------------------------------------
// internal_to_cartesian_point_tb
// Self-checking bench for the point placement pipeline. Each input without a
// known point runs through a behavioural placement model (rotation-mode
// trig, rounding and saturation at the block's widths) and the prediction is
// queued. Each output transfer is compared field by field against the oldest
// prediction. A short directed table of corner cases comes first. Random
// phases follow, under several origin settings, with sender gaps, receiver
// stalls and one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module internal_to_cartesian_point_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Model formats
    localparam int      ROT_STEPS   = 16;             // rotation stages of the DUT
    localparam int      ROT_TABLE   = 24;             // arctangent table length
    localparam int      FRAC        = 16;             // fraction bits of fields
    localparam int      DEG         = 1 << FRAC;      // one degree
    localparam int      FULL_TURN   = 360 * DEG;
    localparam longint  ROT_GAIN    = 64'sd652032874; // 1/K in Q30
    localparam int      LATENCY     = ROT_STEPS + 8;

    // Run shape
    localparam int      PHASES      = 8;
    localparam int      PHASE_ITEMS = 235;
    localparam int      BURST_ITEMS = 60;
    localparam int      HOLD_CYCLES = 300;
    localparam int      STUCK_LIMIT = 2000;
    localparam int      MAX_REPORTS = 10;

    // Index outside the register map; writes to it must be dropped
    localparam logic [itc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // atan(2^-i) in degrees * 2^24
    localparam longint ARC_STEP_DEG [ROT_TABLE] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [itc_pkg::COORD_W-1:0] x;
        logic signed [itc_pkg::COORD_W-1:0] y;
        logic signed [itc_pkg::COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic        [itc_pkg::DIS_W-1:0]   dis;
        logic signed [itc_pkg::ANGLE_W-1:0] ang;
        logic signed [itc_pkg::ANGLE_W-1:0] dih;
        logic                               known;
        point_t                             want;
    } probe_t;

    // Zero distance at the reset origin lands on (1,0,0)
    localparam point_t REST_POINT = '{32'sd65536, 32'sd0, 32'sd0};
    localparam point_t NO_POINT   = '0;

    // Directed corner cases, walked in order at the reset origin
    localparam int NPROBES = 21;
    localparam probe_t PROBES [NPROBES] = '{
        '{24'h000000, 26'(0),             26'(0),             1'b1, REST_POINT},
        '{24'h000000, 26'(FULL_TURN),     26'(-FULL_TURN),    1'b1, REST_POINT},
        '{24'h000000, 26'h2000000,        26'h1FFFFFF,        1'b1, REST_POINT},
        '{24'hFFFFFF, 26'(0),             26'(0),             1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(90*DEG),        26'(0),             1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(90*DEG),        26'(90*DEG),        1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(-90*DEG),       26'(-90*DEG),       1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(180*DEG),       26'(180*DEG),       1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(-180*DEG),      26'(-180*DEG),      1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(90*DEG+1),      26'(-90*DEG-1),     1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(-90*DEG-1),     26'(90*DEG+1),      1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(270*DEG),       26'(450*DEG),       1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(FULL_TURN),     26'(-FULL_TURN),    1'b0, NO_POINT},
        '{24'hFFFFFF, 26'h2000000,        26'h1FFFFFF,        1'b0, NO_POINT},
        '{24'h000001, 26'(30*DEG),        26'(45*DEG),        1'b0, NO_POINT},
        '{24'h800000, 26'(45*DEG),        26'(135*DEG),       1'b0, NO_POINT},
        '{24'hFFFFFF, 26'h3FFFFFF,        26'h3FFFFFF,        1'b0, NO_POINT},
        '{24'h010000, 26'(60*DEG),        26'(-120*DEG),      1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(179*DEG),       26'(-179*DEG),      1'b0, NO_POINT},
        '{24'h7FFFFF, 26'(120*DEG),       26'(300*DEG),       1'b0, NO_POINT},
        '{24'hFFFFFF, 26'(500*DEG),       26'(-500*DEG),      1'b0, NO_POINT}
    };

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic        [itc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic        [itc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic        [itc_pkg::DIS_W-1:0]      bond_length;
    logic signed [itc_pkg::ANGLE_W-1:0]    bond_angle;
    logic signed [itc_pkg::ANGLE_W-1:0]    torsion_angle;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [itc_pkg::COORD_W-1:0]    point_x;
    logic signed [itc_pkg::COORD_W-1:0]    point_y;
    logic signed [itc_pkg::COORD_W-1:0]    point_z;

    // Model copy of the origin registers
    logic signed [itc_pkg::COORD_W-1:0]    org_x;
    logic signed [itc_pkg::COORD_W-1:0]    org_y;
    logic signed [itc_pkg::COORD_W-1:0]    org_z;

    point_t pending_points [$];

    int gap_pct;
    int stall_pct;
    bit hold_req;
    bit in_take;
    bit out_take;
    int stuck_cycles;
    int fail_cnt;
    int n_sent;
    int n_checked;
    int n_settings;

    internal_to_cartesian_point #(
        .TRIG_STAGES (ROT_STEPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .bond_length   (bond_length),
        .bond_angle    (bond_angle),
        .torsion_angle (torsion_angle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Placement model
    // ------------------------------------------------------------------

    // floor((v + 2^(s-1)) / 2^s)
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -longint'(64'sd2147483648))
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Cosine and sine in Q30 of an angle in degrees * 2^16
    function automatic void unit_vector(input longint angle,
                                        output longint cos_q30,
                                        output longint sin_q30);
        longint r;
        longint resid;
        longint vx;
        longint vy;
        longint dx;
        longint dy;
        bit     flip;
        r = angle % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        if (r >= 180 * DEG)
            r -= FULL_TURN;
        // fold into [-90, 90], flipping the vector
        flip = 1'b0;
        if (r > 90 * DEG)
        begin
            r -= 180 * DEG;
            flip = 1'b1;
        end
        else if (r < -90 * DEG)
        begin
            r += 180 * DEG;
            flip = 1'b1;
        end
        resid = r <<< 8;
        vx = ROT_GAIN;
        vy = 0;
        for (int i = 0; i < ROT_STEPS && i < ROT_TABLE; i++)
        begin
            dx = vx >>> i;
            dy = vy >>> i;
            if (resid >= 0)
            begin
                vx -= dy;
                vy += dx;
                resid -= ARC_STEP_DEG[i];
            end
            else
            begin
                vx += dy;
                vy -= dx;
                resid += ARC_STEP_DEG[i];
            end
        end
        cos_q30 = flip ? -vx : vx;
        sin_q30 = flip ? -vy : vy;
    endfunction

    function automatic point_t place_point(input logic [itc_pkg::DIS_W-1:0] dis,
                                           input logic signed [itc_pkg::ANGLE_W-1:0] ang,
                                           input logic signed [itc_pkg::ANGLE_W-1:0] dih);
        longint d;
        longint ca;
        longint sa;
        longint cd;
        longint sd;
        longint q;
        point_t p;
        d = longint'(dis);
        unit_vector(longint'(ang), ca, sa);
        unit_vector(longint'(dih), cd, sd);
        // q carries two extra fraction bits
        q = round_shift(d * sa, 28);
        p.x = clamp32(longint'(org_x) + (longint'(1) <<< FRAC) - round_shift(d * ca, 30));
        p.y = clamp32(longint'(org_y) + round_shift(q * cd, 32));
        p.z = clamp32(longint'(org_z) + round_shift(q * sd, 32));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [itc_pkg::DIS_W-1:0] pick_length();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return itc_pkg::DIS_W'($urandom_range(255));
            default: return itc_pkg::DIS_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [itc_pkg::ANGLE_W-1:0] pick_angle();
        int k;
        k = $urandom_range(8);
        case ($urandom_range(9))
            0, 1, 2: return itc_pkg::ANGLE_W'($urandom);
            // quadrant boundaries and their neighbours
            3, 4: return itc_pkg::ANGLE_W'((k * 90 - 360) * DEG
                                           + int'($urandom_range(2)) - 1);
            default: return itc_pkg::ANGLE_W'(int'($urandom_range(2 * FULL_TURN))
                                              - FULL_TURN);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offer one placement and queue its expected point once transferred
    task automatic offer_placement(input logic [itc_pkg::DIS_W-1:0] dis,
                                   input logic signed [itc_pkg::ANGLE_W-1:0] ang,
                                   input logic signed [itc_pkg::ANGLE_W-1:0] dih,
                                   input point_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        bond_length   <= dis;
        bond_angle    <= ang;
        torsion_angle <= dih;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        pending_points.push_back(want);
        n_sent++;
    endtask

    task automatic send_random(input int count);
        logic [itc_pkg::DIS_W-1:0]   dis;
        logic signed [itc_pkg::ANGLE_W-1:0] ang;
        logic signed [itc_pkg::ANGLE_W-1:0] dih;
        for (int n = 0; n < count; n++)
        begin
            dis = pick_length();
            ang = pick_angle();
            dih = pick_angle();
            offer_placement(dis, ang, dih, place_point(dis, ang, dih));
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Write all three origins, then junk to the unused index
    task automatic load_origin(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz);
        logic [itc_pkg::CFG_IDX_W-1:0] idx [4];
        logic [31:0]                   val [4];
        idx = '{itc_pkg::REG_ORIGIN_X, itc_pkg::REG_ORIGIN_Y,
                itc_pkg::REG_ORIGIN_Z, REG_UNUSED};
        val = '{ox, oy, oz, $urandom};
        for (int k = 0; k < 4; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        org_x = ox;
        org_y = oy;
        org_z = oz;
        n_settings++;
    endtask

    task automatic set_idling(input int gap, input int stall);
        @(negedge clk);
        gap_pct   = gap;
        stall_pct = stall;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Transfer monitor and result check, sampled mid-cycle
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        point_t want;
        in_take  = rst_n && in_valid && !in_stall;
        out_take = rst_n && out_valid && !out_stall;
        if (out_take)
        begin
            if (pending_points.size() == 0)
                note_failure($sformatf("result (%0d,%0d,%0d) with nothing pending",
                                       point_x, point_y, point_z));
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x || point_y !== want.y || point_z !== want.z)
                    note_failure($sformatf("result %0d: want (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                           n_checked, want.x, want.y, want.z,
                                           point_x, point_y, point_z));
                n_checked++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (in_take || out_take)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("no transfer for %0d cycles", STUCK_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        bond_length   = '0;
        bond_angle    = '0;
        torsion_angle = '0;
        org_x         = '0;
        org_y         = '0;
        org_z         = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        stuck_cycles  = 0;
        fail_cnt      = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_settings    = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at the reset origin
        for (int r = 0; r < NPROBES; r++)
            offer_placement(PROBES[r].dis, PROBES[r].ang, PROBES[r].dih,
                            PROBES[r].known ? PROBES[r].want
                                            : place_point(PROBES[r].dis, PROBES[r].ang,
                                                          PROBES[r].dih));
        in_valid <= 1'b0;
        wait_for_results();

        // random phases: origin extremes first, then random origins
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_origin(32'h0, 32'h0, 32'h0);
                1: load_origin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
                2: load_origin(32'h80000000, 32'h80000000, 32'h80000000);
                3: load_origin(32'h7FFFFFFF, 32'h80000000, 32'h0);
                default: load_origin($urandom, $urandom, $urandom);
            endcase
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(83, 0);
                2: set_idling(0, 83);
                default: set_idling(26, 26);
            endcase
            send_random(PHASE_ITEMS);
            wait_for_results();
        end

        // long output hold-off with the sender pushing flat out
        set_idling(0, 0);
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
        send_random(BURST_ITEMS);
        wait_for_results();

        repeat (LATENCY + 16) @(posedge clk);
        if (pending_points.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_points.size()));

        $display("placed %0d points under %0d origin settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("idling: none, sender, receiver, both; one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/itc_pkg.sv
src/itc_prep.sv
src/itc_cordic_cell.sv
src/itc_tail.sv
src/internal_to_cartesian_point.sv
src/itc_checker.sv
dv/internal_to_cartesian_point_tb.sv
